FILE: hw/rtl/crsu_pkg.sv
`default_nettype none

package crsu_pkg;

  localparam int POS_W   = 16;
  localparam int VALUE_W = 64;

  localparam int IN_DATA_W  = 152;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [VALUE_W-1:0] value_t;

  typedef enum logic [1:0] {
    ACT_CHOICE    = 2'd0,
    ACT_BALANCE   = 2'd1,
    ACT_REPROGRAM = 2'd2,
    ACT_QUERY     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    CMP_EQ = 3'd0,
    CMP_GT = 3'd1,
    CMP_LT = 3'd2,
    CMP_GE = 3'd3,
    CMP_LE = 3'd4,
    CMP_NE = 3'd5
  } cmp_kind_t;

  typedef struct packed {
    action_t   action;
    value_t    left_value;
    value_t    right_value;
    cmp_kind_t compare_kind;
    pos_t      position;
  } req_t;

  typedef struct packed {
    logic skip;
    logic nest_error;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/conditional_region_skip_unit.sv
// registered path: input register, then result register, from input request to result valid
// throughput: one request per cycle; the marker state updates in the same cycle
// that a request leaves the input register, so back-to-back requests see it
// while a result waits the empty input register still takes one request, then stalls
// reset: synchronous active-low rst_n clears valid flags and all marker state
`default_nettype none

module conditional_region_skip_unit
  import crsu_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  // left_value[63:0], right_value[127:64], compare_kind[130:128], position[146:131]
  input  wire [IN_DATA_W-1:0]   in_tdata,
  // action[1:0]
  input  wire [IN_USER_W-1:0]   in_tuser,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  // skip[0], nest_error[1]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic in_valid_r;
  req_t in_req_r;
  logic out_valid_r;
  res_t out_res_r;

  logic out_free;
  logic fire;
  res_t res;
  req_t req_in;

  assign out_free  = !out_valid_r || out_tready;
  assign fire      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_comb begin
    req_in.action       = action_t'(in_tuser[1:0]);
    req_in.left_value   = in_tdata[63:0];
    req_in.right_value  = in_tdata[127:64];
    req_in.compare_kind = cmp_kind_t'(in_tdata[130:128]);
    req_in.position     = pos_t'(in_tdata[146:131]);
  end

  crsu_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .req  (in_req_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_req_r <= req_in;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-2){1'b0}}, out_res_r.nest_error, out_res_r.skip};

endmodule

`default_nettype wire

FILE: hw/rtl/crsu_cmp.sv
`default_nettype none

module crsu_cmp
  import crsu_pkg::*;
(
  input  wire value_t    left_value,
  input  wire value_t    right_value,
  input  wire cmp_kind_t compare_kind,
  output logic           outcome
);

  logic eq;
  logic lt;

  assign eq = (left_value == right_value);
  assign lt = (left_value < right_value);

  always_comb begin
    case (compare_kind)
      CMP_EQ:  outcome = eq;
      CMP_GT:  outcome = !eq && !lt;
      CMP_LT:  outcome = lt;
      CMP_GE:  outcome = !lt;
      CMP_LE:  outcome = lt || eq;
      CMP_NE:  outcome = !eq;
      default: outcome = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/crsu_ctrl.sv
`default_nettype none

module crsu_ctrl
  import crsu_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        fire,
  input  wire req_t  req,
  output res_t       res
);

  logic if_seen_r, if_seen_nxt;
  logic else_seen_r, else_seen_nxt;
  logic end_seen_r, end_seen_nxt;
  logic outcome_true_r, outcome_true_nxt;
  pos_t if_position_r, if_position_nxt;
  pos_t else_position_r, else_position_nxt;
  pos_t end_position_r, end_position_nxt;

  logic outcome;
  logic nested;
  logic after_if;
  logic before_else;
  logic after_else;
  logic before_end;
  logic query_skip;
  pos_t p;

  crsu_cmp u_cmp (
    .left_value  (req.left_value),
    .right_value (req.right_value),
    .compare_kind(req.compare_kind),
    .outcome     (outcome)
  );

  assign p           = req.position;
  assign after_if    = (if_position_r < p);
  assign before_else = (p < else_position_r);
  assign after_else  = (else_position_r < p);
  assign before_end  = (p < end_position_r);
  assign nested      = after_if && before_end;

  // skip decision for a query
  always_comb begin
    query_skip = 1'b0;
    if (if_seen_r) begin
      if (else_seen_r) begin
        if (after_if && before_else) begin
          query_skip = !outcome_true_r;
        end else if (after_else && (!end_seen_r || before_end)) begin
          query_skip = outcome_true_r;
        end
      end else if (after_if && (!end_seen_r || before_end)) begin
        query_skip = !outcome_true_r;
      end
    end
  end

  always_comb begin
    res.skip       = (req.action == ACT_QUERY) && query_skip;
    res.nest_error = (req.action == ACT_CHOICE) && nested;
  end

  always_comb begin
    if_seen_nxt       = if_seen_r;
    else_seen_nxt     = else_seen_r;
    end_seen_nxt      = end_seen_r;
    outcome_true_nxt  = outcome_true_r;
    if_position_nxt   = if_position_r;
    else_position_nxt = else_position_r;
    end_position_nxt  = end_position_r;
    if (fire) begin
      case (req.action)
        ACT_CHOICE: begin
          if (!nested) begin
            if_seen_nxt      = 1'b1;
            else_seen_nxt    = 1'b0;
            end_seen_nxt     = 1'b0;
            if_position_nxt  = p;
            outcome_true_nxt = outcome;
          end
        end
        ACT_BALANCE: begin
          else_seen_nxt     = 1'b1;
          else_position_nxt = p;
        end
        ACT_REPROGRAM: begin
          end_seen_nxt     = 1'b1;
          end_position_nxt = p;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      if_seen_r       <= 1'b0;
      else_seen_r     <= 1'b0;
      end_seen_r      <= 1'b0;
      outcome_true_r  <= 1'b0;
      if_position_r   <= '0;
      else_position_r <= '0;
      end_position_r  <= '0;
    end else begin
      if_seen_r       <= if_seen_nxt;
      else_seen_r     <= else_seen_nxt;
      end_seen_r      <= end_seen_nxt;
      outcome_true_r  <= outcome_true_nxt;
      if_position_r   <= if_position_nxt;
      else_position_r <= else_position_nxt;
      end_position_r  <= end_position_nxt;
    end
  end

`ifndef SYNTHESIS
  a_choice_clears_marks: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (req.action == ACT_CHOICE) && !res.nest_error
      |=> if_seen_r && !else_seen_r && !end_seen_r)
    else $error("accepted choice did not reset marks");

  a_rejected_choice_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.nest_error
      |=> $stable(if_position_r) && $stable(outcome_true_r) && $stable(if_seen_r))
    else $error("rejected choice changed state");

  a_skip_needs_choice: assert property (@(posedge clk) disable iff (!rst_n)
    res.skip |-> if_seen_r && (req.action == ACT_QUERY))
    else $error("skip without recorded choice");

  a_error_only_on_choice: assert property (@(posedge clk) disable iff (!rst_n)
    res.nest_error |-> (req.action == ACT_CHOICE) && !res.skip)
    else $error("nest error on non-choice request");
`endif

endmodule

`default_nettype wire
